// ===== rtl/psc_pkg.sv =====
package psc_pkg;

  localparam int unsigned NumStats = 24;

  // Request codes
  localparam logic [3:0] ReqPacket   = 4'd0;
  localparam logic [3:0] ReqDrop     = 4'd1;
  localparam logic [3:0] ReqError    = 4'd2;
  localparam logic [3:0] ReqLatency  = 4'd3;
  localparam logic [3:0] ReqFilter   = 4'd4;
  localparam logic [3:0] ReqFill     = 4'd5;
  localparam logic [3:0] ReqSnapshot = 4'd6;
  localparam logic [3:0] ReqClear    = 4'd7;
  localparam logic [3:0] ReqStart    = 4'd8;

  // Datapath divider operand selects
  localparam logic [2:0] DivUptime  = 3'd0;
  localparam logic [2:0] DivElapsed = 3'd1;
  localparam logic [2:0] DivRxRate  = 3'd2;
  localparam logic [2:0] DivTxRate  = 3'd3;
  localparam logic [2:0] DivDropPct = 3'd4;
  localparam logic [2:0] DivAvgLat  = 3'd5;

  typedef struct packed {
    logic [3:0]  req_type;
    logic        inbound;
    logic [1:0]  iface_kind;
    logic [15:0] byte_count;
    logic [1:0]  decision_code;
    logic [31:0] duration_us;
    logic [6:0]  fill_percent;
    logic [62:0] now_time;
  } in_word_t;

  typedef struct packed {
    logic [4:0]  stat_index;
    logic [63:0] stat_value;
    logic        last;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic       event_en;   // apply a counting event from the input word
    logic       capture;    // capture the time stamp of the snapshot input word
    logic       div_start;  // launch a division
    logic [2:0] div_sel;
    logic       commit;     // latch previous-snapshot values
    logic       emit;       // load the output register with stat_idx
    logic [4:0] stat_idx;
  } psc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
  } psc_sts_t;

endpackage

// ===== rtl/packet_statistics_counter_unit.sv =====
// Packet statistics counter unit. Counting events (packet, drop, error,
// latency, filter, fill, clear, start) are taken one word per cycle. A
// snapshot word stalls the input until its last result word is loaded:
// uptime and elapsed milliseconds divide by constants through a reciprocal
// multiply, the four remaining 64-bit divisions run in turn on one shared
// radix-2 divider, then 24 result words leave through the output register,
// one per cycle while the sink does not stall; sink stalls lengthen the
// input stall.
module packet_statistics_counter_unit import psc_pkg::*; #(
  parameter int unsigned STAT_WIDTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  psc_cmd_t cmd;
  psc_sts_t sts;

  psc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .req_type_i(in_word_i.req_type), .in_stall_o,
    .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  psc_datapath #(.StatWidth(STAT_WIDTH)) u_dp (
    .clk_i, .rst_ni,
    .word_i(in_word_i), .cmd_i(cmd), .sts_o(sts), .out_o(out_word_o)
  );

endmodule

// ===== rtl/psc_div.sv =====
module psc_div import psc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [63:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quot_o
);

  logic [63:0] quot_q, quot_d;
  logic [63:0] rem_q, rem_d;
  logic [63:0] dvs_q, dvs_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [64:0] trial;
  logic [64:0] shifted;

  // One quotient bit per cycle, restoring
  always_comb begin
    quot_d  = quot_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q, quot_q[63]};
    trial   = shifted - {1'b0, dvs_q};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = 7'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (dvs_q == 64'd0) begin
        quot_d = '0;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        if (!trial[64]) begin
          rem_d = trial[63:0];
          quot_d = {quot_q[62:0], 1'b1};
        end else begin
          rem_d = shifted[63:0];
          quot_d = {quot_q[62:0], 1'b0};
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd63) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// Division by 10^7 or 10^4 through reciprocal multiplication. The
// power-of-two part of the divisor is shifted out first, then the operand
// is multiplied by a rounded-up reciprocal of the odd part and the top bits
// are kept. Four 32x32 partial products, one per cycle; done_o is a
// registered pulse once the last partial product is accumulated.
module psc_cdiv import psc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        elapsed_i,
  input  logic [63:0] dividend_i,
  output logic        done_o,
  output logic [63:0] quot_o
);

  // ceil(2^74 / 78125) for 10^7 = 2^7 * 78125, ceil(2^70 / 625) for 10^4 = 2^4 * 625
  localparam logic [63:0] RecipUptime  = 64'd241785163922925835;
  localparam logic [63:0] RecipElapsed = 64'd1888946593147858086;

  logic [63:0]  a_q, a_d;
  logic [127:0] acc_q, acc_d;
  logic [1:0]   cnt_q, cnt_d;
  logic         sel_q, sel_d;
  logic         busy_q, busy_d;
  logic         done_q, done_d;
  logic [63:0]  recip;
  logic [31:0]  a_part, r_part;
  logic [63:0]  prod;
  logic [127:0] prod_ext;

  assign recip  = sel_q ? RecipElapsed : RecipUptime;
  assign a_part = cnt_q[1] ? a_q[63:32] : a_q[31:0];
  assign r_part = cnt_q[0] ? recip[63:32] : recip[31:0];
  assign prod   = {32'd0, a_part} * {32'd0, r_part};

  // Align the partial product to its column
  always_comb begin
    case (cnt_q) inside
      2'd0:       prod_ext = {64'd0, prod};
      2'd1, 2'd2: prod_ext = {32'd0, prod, 32'd0};
      default:    prod_ext = {prod, 64'd0};
    endcase
  end

  // Load the shifted operand, then accumulate one partial product per cycle
  always_comb begin
    a_d    = a_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    sel_d  = sel_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = elapsed_i ? {4'd0, dividend_i[63:4]} : {7'd0, dividend_i[63:7]};
      acc_d  = '0;
      cnt_d  = 2'd0;
      sel_d  = elapsed_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = acc_q + prod_ext;
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == 2'd3) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    acc_q <= acc_d;
    sel_q <= sel_d;
  end

  assign done_o = done_q;
  assign quot_o = sel_q ? {6'd0, acc_q[127:70]} : {10'd0, acc_q[127:74]};

endmodule

// ===== rtl/psc_datapath.sv =====
module psc_datapath import psc_pkg::*; #(
  parameter int unsigned StatWidth = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  word_i,
  input  psc_cmd_t  cmd_i,
  output psc_sts_t  sts_o,
  output out_word_t out_o
);

  typedef logic [StatWidth-1:0] stat_t;

  stat_t cnt_q [15];
  stat_t cnt_d [15];
  stat_t feval_q, lat_tot_q, lat_n_q;
  logic [63:0] lat_peak_q, start_q, prev_time_q, now_q;
  stat_t prev_rx_q, prev_tx_q;
  logic [6:0] fill_cur_q, fill_peak_q;
  logic [63:0] uptime_q, elapsed_q, rxr_q, txr_q, pct_q, avg_q;
  logic [63:0] now64, dvd, dvs, quot;
  logic [63:0] sdiv_quot, cdiv_quot;
  logic        div_done, sdiv_done, cdiv_done, const_div;
  out_word_t   out_q;
  stat_t       tot, drx, dtx;
  logic [63:0] stat_val;
  logic [3:0]  kidx;
  logic [3:0]  fidx;

  assign now64 = {1'b0, word_i.now_time};
  assign kidx  = 4'd6 + {1'b0, word_i.iface_kind, ~word_i.inbound};
  assign fidx  = 4'd12 + {2'b0, word_i.decision_code};

  // Counter updates for one event
  always_comb begin
    for (int i = 0; i < 15; i++) cnt_d[i] = cnt_q[i];
    unique case (word_i.req_type) inside
      ReqPacket: begin
        if (word_i.inbound) begin
          cnt_d[0] = cnt_q[0] + stat_t'(1);
          cnt_d[2] = cnt_q[2] + stat_t'(word_i.byte_count);
        end else begin
          cnt_d[1] = cnt_q[1] + stat_t'(1);
          cnt_d[3] = cnt_q[3] + stat_t'(word_i.byte_count);
        end
        if (word_i.iface_kind != 2'd3) cnt_d[kidx] = cnt_q[kidx] + stat_t'(1);
      end
      ReqDrop:   cnt_d[4] = cnt_q[4] + stat_t'(1);
      ReqError:  cnt_d[5] = cnt_q[5] + stat_t'(1);
      ReqFilter: if (word_i.decision_code != 2'd3) cnt_d[fidx] = cnt_q[fidx] + stat_t'(1);
      ReqClear, ReqStart: begin
        for (int i = 0; i < 15; i++) cnt_d[i] = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 15; i++) cnt_q[i] <= '0;
      feval_q <= '0; lat_tot_q <= '0; lat_n_q <= '0; lat_peak_q <= '0;
      start_q <= '0; prev_time_q <= '0; prev_rx_q <= '0; prev_tx_q <= '0;
      fill_cur_q <= '0; fill_peak_q <= '0;
    end else if (cmd_i.event_en) begin
      for (int i = 0; i < 15; i++) cnt_q[i] <= cnt_d[i];
      case (word_i.req_type) inside
        ReqLatency: begin
          lat_tot_q <= lat_tot_q + stat_t'(word_i.duration_us);
          lat_n_q   <= lat_n_q + stat_t'(1);
          if ({32'd0, word_i.duration_us} > lat_peak_q)
            lat_peak_q <= {32'd0, word_i.duration_us};
        end
        ReqFilter: feval_q <= feval_q + stat_t'(1);
        ReqFill: begin
          fill_cur_q <= word_i.fill_percent;
          if (word_i.fill_percent > fill_peak_q) fill_peak_q <= word_i.fill_percent;
        end
        ReqClear, ReqStart: begin
          feval_q <= '0; lat_tot_q <= '0; lat_n_q <= '0; lat_peak_q <= '0;
          fill_cur_q <= '0; prev_rx_q <= '0; prev_tx_q <= '0;
          prev_time_q <= now64;
          if (word_i.req_type == ReqStart) begin
            fill_peak_q <= '0;
            start_q <= now64;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.commit) begin
      prev_time_q <= now_q;
      prev_rx_q   <= cnt_q[0];
      prev_tx_q   <= cnt_q[1];
    end
  end

  // Division operands
  assign drx = cnt_q[0] - prev_rx_q;
  assign dtx = cnt_q[1] - prev_tx_q;
  assign tot = cnt_q[0] + cnt_q[1];
  always_comb begin
    dvd = '0;
    dvs = '0;
    case (cmd_i.div_sel)
      DivUptime:  dvd = now_q - start_q;
      DivElapsed: dvd = now_q - prev_time_q;
      DivRxRate:  begin dvd = 64'(drx) * 64'd1000; dvs = elapsed_q;    end
      DivTxRate:  begin dvd = 64'(dtx) * 64'd1000; dvs = elapsed_q;    end
      DivDropPct: begin dvd = 64'(cnt_q[4]) * 64'd100; dvs = 64'(tot); end
      DivAvgLat:  begin dvd = 64'(lat_tot_q);      dvs = 64'(lat_n_q); end
      default: ;
    endcase
  end

  // Constant divisors go to the reciprocal unit, the rest to the serial divider
  assign const_div = (cmd_i.div_sel == DivUptime) || (cmd_i.div_sel == DivElapsed);

  psc_div u_div (
    .clk_i, .rst_ni,
    .start_i(cmd_i.div_start && !const_div), .dividend_i(dvd), .divisor_i(dvs),
    .done_o(sdiv_done), .quot_o(sdiv_quot)
  );

  psc_cdiv u_cdiv (
    .clk_i, .rst_ni,
    .start_i(cmd_i.div_start && const_div), .elapsed_i(cmd_i.div_sel == DivElapsed),
    .dividend_i(dvd), .done_o(cdiv_done), .quot_o(cdiv_quot)
  );

  assign div_done = sdiv_done | cdiv_done;
  assign quot     = const_div ? cdiv_quot : sdiv_quot;

  // Capture division results
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) now_q <= now64;
    if (div_done) begin
      case (cmd_i.div_sel)
        DivUptime:  uptime_q  <= quot;
        DivElapsed: elapsed_q <= quot;
        DivRxRate:  rxr_q     <= quot;
        DivTxRate:  txr_q     <= quot;
        DivDropPct: pct_q     <= (quot > 64'd100) ? 64'd100 : quot;
        DivAvgLat:  avg_q     <= quot;
        default: ;
      endcase
    end
  end

  // Select the statistic being emitted
  always_comb begin
    stat_val = '0;
    if (cmd_i.stat_idx < 5'd15) stat_val = 64'(cnt_q[cmd_i.stat_idx[3:0]]);
    else begin
      case (cmd_i.stat_idx)
        5'd15: stat_val = 64'(fill_cur_q);
        5'd16: stat_val = 64'(fill_peak_q);
        5'd17: stat_val = uptime_q;
        5'd18: stat_val = rxr_q;
        5'd19: stat_val = txr_q;
        5'd20: stat_val = pct_q;
        5'd21: stat_val = avg_q;
        5'd22: stat_val = lat_peak_q;
        5'd23: stat_val = now_q;
        default: stat_val = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.stat_index <= cmd_i.stat_idx;
      out_q.stat_value <= stat_val;
      out_q.last       <= (cmd_i.stat_idx == 5'(NumStats - 1));
    end
  end

  assign sts_o.div_done = div_done;
  assign out_o = out_q;

endmodule

// ===== rtl/psc_ctrl.sv =====
module psc_ctrl import psc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic [3:0] req_type_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  psc_sts_t  sts_i,
  output psc_cmd_t  cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0] state_q, state_d;
  logic [2:0] sel_q, sel_d;
  logic [4:0] idx_q, idx_d;
  logic       ov_q, ov_d;
  logic       kick_q, kick_d;
  logic       acc;

  assign in_stall_o = (state_q != StIdle);
  assign acc = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q; sel_d = sel_q; idx_d = idx_q; ov_d = ov_q; kick_d = 1'b0;
    cmd_o = '0;
    cmd_o.div_sel  = sel_q;
    cmd_o.stat_idx = idx_q;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    unique case (state_q)
      StIdle: if (acc) begin
        if (req_type_i == ReqSnapshot) begin
          cmd_o.capture = 1'b1;
          sel_d = DivUptime;
          kick_d = 1'b1;
          state_d = StDiv;
        end else cmd_o.event_en = 1'b1;
      end
      StDiv: begin
        cmd_o.div_start = kick_q;
        if (sts_i.div_done) begin
          if (sel_q == DivAvgLat) begin
            idx_d = '0;
            state_d = StEmit;
          end else begin
            sel_d = sel_q + 3'd1;
            kick_d = 1'b1;
          end
        end
      end
      StEmit: if (!ov_q || !out_stall_i) begin
        cmd_o.emit = 1'b1;
        ov_d = 1'b1;
        if (idx_q == 5'(NumStats - 1)) begin
          cmd_o.commit = 1'b1;
          state_d = StIdle;
        end else idx_d = idx_q + 5'd1;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; sel_q <= '0; idx_q <= '0; ov_q <= 1'b0; kick_q <= 1'b0;
    end else begin
      state_q <= state_d; sel_q <= sel_d; idx_q <= idx_d; ov_q <= ov_d; kick_q <= kick_d;
    end
  end

  assign out_valid_o = ov_q;

endmodule
